// ===== rtl/core/cmt_pkg.sv =====
// Shared types, sizes and helpers for the CAN receive mailbox table.
package cmt_pkg;

    localparam int MAILBOXES      = 16;
    localparam int STANDARD_SLOTS = 8;
    localparam int STD_END        = (STANDARD_SLOTS < MAILBOXES) ? STANDARD_SLOTS : MAILBOXES;

    localparam int FUNC_W     = 3;
    localparam int ID_W       = 29;
    localparam int SLOT_W     = 6;
    localparam int SLOT_OUT_W = 7;
    localparam int DLC_W      = 4;
    localparam int DATA_W     = 64;
    localparam int MAX_LEN    = 8;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD    = 3'd0,
        FN_REMOVE = 3'd1,
        FN_RECV   = 3'd2,
        FN_READ   = 3'd3,
        FN_CHECK  = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_COMMIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_func                func;
        logic [ID_W-1:0]      ident;
        logic                 ext;
        logic                 rtr;
        logic [SLOT_W-1:0]    slot;
        logic [DLC_W-1:0]     len;
        logic [DATA_W-1:0]    payload;
    } t_cmd;

    typedef struct packed {
        logic match_en;
        logic commit_en;
        logic hint_any;
    } t_ctl;

    typedef struct packed {
        logic                  taken;
        logic [SLOT_OUT_W-1:0] idx;
        logic                  en;
        logic                  nw;
        logic [ID_W-1:0]       ident;
        logic [DLC_W-1:0]      dlc;
        logic [DATA_W-1:0]     data;
    } t_link;

    function automatic logic [DATA_W-1:0] len_mask(input logic [DLC_W-1:0] len);
        logic [DATA_W-1:0] m;
        for (int b = 0; b < MAX_LEN; b++) begin
            m[b*8 +: 8] = (DLC_W'(b) < len) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/cmt_cell.sv =====
// One mailbox slot: stored frame state, local match flags and a link to its neighbor.
module cmt_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cmt_pkg::t_cmd                   i_cmd,
    input  cmt_pkg::t_ctl                   i_ctl,
    input  logic [cmt_pkg::SLOT_OUT_W-1:0]  i_index,
    input  cmt_pkg::t_link                  i_link,
    output cmt_pkg::t_link                  o_link,
    output logic                            o_hint
);
    import cmt_pkg::*;

    logic [ID_W-1:0]   r_ident;
    logic              r_en;
    logic              r_new;
    logic              r_rtr;
    logic              r_ext;
    logic [DLC_W-1:0]  r_dlc;
    logic [DATA_W-1:0] r_data;
    logic              r_free;
    logic              r_scan;
    logic              r_hint;

    logic w_in_half;
    logic w_at_slot;
    logic w_free;
    logic w_scan;
    logic w_sel;

    always_comb begin
        w_in_half = i_cmd.ext ? (i_index >= SLOT_OUT_W'(STD_END))
                              : (i_index <  SLOT_OUT_W'(STD_END));
        w_at_slot = (i_index == {1'b0, i_cmd.slot});
        w_free    = w_in_half && !r_en;
        w_scan    = w_in_half && (r_ident == i_cmd.ident) && (r_rtr == i_cmd.rtr);
        o_hint    = w_at_slot && (r_ident == i_cmd.ident) && (r_ext == i_cmd.ext)
                    && (r_rtr == i_cmd.rtr);
    end

    always_comb begin
        unique case (i_cmd.func)
            FN_ADD:    w_sel = r_free && !i_link.taken;
            FN_RECV:   w_sel = i_ctl.hint_any ? r_hint : (r_scan && !i_link.taken);
            FN_REMOVE: w_sel = w_at_slot;
            FN_READ:   w_sel = w_at_slot;
            FN_CHECK:  w_sel = w_at_slot;
            default:   w_sel = 1'b0;
        endcase
    end

    always_comb begin
        o_link.taken = i_link.taken | w_sel;
        o_link.idx   = i_link.idx   | (w_sel ? i_index : '0);
        o_link.en    = i_link.en    | (w_sel & r_en);
        o_link.nw    = i_link.nw    | (w_sel & r_new);
        o_link.ident = i_link.ident | (w_sel ? r_ident : '0);
        o_link.dlc   = i_link.dlc   | (w_sel ? r_dlc : '0);
        o_link.data  = i_link.data  | (w_sel ? r_data : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ident <= '0;
            r_en    <= 1'b0;
            r_new   <= 1'b0;
            r_rtr   <= 1'b0;
            r_ext   <= 1'b0;
            r_dlc   <= '0;
            r_data  <= '0;
            r_free  <= 1'b0;
            r_scan  <= 1'b0;
            r_hint  <= 1'b0;
        end else begin
            if (i_ctl.match_en) begin
                r_free <= w_free;
                r_scan <= w_scan;
                r_hint <= o_hint;
            end
            if (i_ctl.commit_en && w_sel) begin
                unique case (i_cmd.func)
                    FN_ADD: begin
                        r_ident <= i_cmd.ident;
                        r_en    <= 1'b1;
                        r_rtr   <= i_cmd.rtr;
                        r_ext   <= i_cmd.ext;
                    end
                    FN_REMOVE: begin
                        r_en <= 1'b0;
                    end
                    FN_RECV: begin
                        r_dlc  <= i_cmd.len;
                        r_data <= i_cmd.payload & len_mask(i_cmd.len);
                        if (r_en) begin
                            r_new <= 1'b1;
                        end
                    end
                    FN_READ: begin
                        if (r_en) begin
                            r_new <= 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ===== rtl/core/can_rx_mailbox_table_top.sv =====
// Top level of the CAN receive mailbox table: command register, control sequencer, slot row.
// Sequence: an item passes the match and commit states to the output state, valid until it
// transfers. The sequencer holds one item at a time, stalling input until that transfer, while
// every slot cell compares in parallel and the neighbor link resolves.
// Reset: synchronous active low; all slots are cleared and disabled, the sequencer goes idle.
module can_rx_mailbox_table_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [cmt_pkg::FUNC_W-1:0]        i_func,
    input  logic [cmt_pkg::ID_W-1:0]          i_ident,
    input  logic                              i_extended,
    input  logic                              i_remote,
    input  logic [cmt_pkg::SLOT_W-1:0]        i_slot,
    input  logic [cmt_pkg::DLC_W-1:0]         i_dlc,
    input  logic [cmt_pkg::DATA_W-1:0]        i_payload,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_status,
    output logic [cmt_pkg::SLOT_OUT_W-1:0]    o_slot_out,
    output logic                              o_hit,
    output logic [cmt_pkg::ID_W-1:0]          o_ident_out,
    output logic [cmt_pkg::DLC_W-1:0]         o_dlc_out,
    output logic [cmt_pkg::DATA_W-1:0]        o_payload_out
);
    import cmt_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   r_cmd;
    logic   r_hint_any;
    t_ctl   w_ctl;

    logic                  r_status;
    logic [SLOT_OUT_W-1:0] r_slot_out;
    logic                  r_hit;
    logic [ID_W-1:0]       r_ident_out;
    logic [DLC_W-1:0]      r_dlc_out;
    logic [DATA_W-1:0]     r_payload_out;

    logic                  n_status;
    logic [SLOT_OUT_W-1:0] n_slot_out;
    logic                  n_hit;
    logic [ID_W-1:0]       n_ident_out;
    logic [DLC_W-1:0]      n_dlc_out;
    logic [DATA_W-1:0]     n_payload_out;

    t_link            w_link [MAILBOXES+1];
    logic [MAILBOXES-1:0] w_hint;
    logic             w_accept;
    logic [DLC_W-1:0] w_len;
    logic             w_ok;
    t_link            w_end;

    assign w_link[0] = '0;
    assign w_end     = w_link[MAILBOXES];

    for (genvar g = 0; g < MAILBOXES; g++) begin : g_cell
        cmt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (r_cmd),
            .i_ctl   (w_ctl),
            .i_index (SLOT_OUT_W'(g)),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1]),
            .o_hint  (w_hint[g])
        );
    end

    always_comb begin
        unique case (r_state)
            ST_IDLE:   n_state = i_valid ? ST_MATCH : ST_IDLE;
            ST_MATCH:  n_state = ST_COMMIT;
            ST_COMMIT: n_state = ST_OUT;
            ST_OUT:    n_state = i_stall ? ST_OUT : ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall         = (r_state != ST_IDLE);
        o_valid         = (r_state == ST_OUT);
        w_ctl.match_en  = (r_state == ST_MATCH);
        w_ctl.commit_en = (r_state == ST_COMMIT);
        w_ctl.hint_any  = r_hint_any;
    end

    assign w_accept = i_valid && !o_stall;
    assign w_len    = (i_dlc > DLC_W'(MAX_LEN)) ? DLC_W'(MAX_LEN) : i_dlc;
    assign w_ok     = w_end.taken && w_end.en && w_end.nw;

    always_comb begin
        n_status      = 1'b1;
        n_slot_out    = '0;
        n_hit         = 1'b0;
        n_ident_out   = '0;
        n_dlc_out     = '0;
        n_payload_out = '0;
        unique case (r_cmd.func)
            FN_ADD: begin
                if (w_end.taken) begin
                    n_status   = 1'b0;
                    n_slot_out = w_end.idx;
                end else begin
                    n_slot_out = r_cmd.ext ? SLOT_OUT_W'(MAILBOXES) : SLOT_OUT_W'(STD_END);
                end
            end
            FN_REMOVE: begin
                n_status   = 1'b0;
                n_slot_out = {1'b0, r_cmd.slot};
            end
            FN_RECV: begin
                if (w_end.taken) begin
                    n_status   = 1'b0;
                    n_slot_out = w_end.idx;
                    n_hit      = w_end.en;
                end
            end
            FN_READ: begin
                n_slot_out = {1'b0, r_cmd.slot};
                n_status   = !w_ok;
                n_hit      = w_ok;
                if (w_ok) begin
                    n_ident_out   = w_end.ident;
                    n_dlc_out     = w_end.dlc;
                    n_payload_out = w_end.data & len_mask(w_end.dlc);
                end
            end
            FN_CHECK: begin
                n_slot_out = {1'b0, r_cmd.slot};
                n_status   = !w_ok;
                n_hit      = w_ok;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_hint_any <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctl.match_en) begin
                r_hint_any <= |w_hint;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd.func    <= t_func'(i_func);
            r_cmd.ident   <= i_ident;
            r_cmd.ext     <= i_extended;
            r_cmd.rtr     <= i_remote;
            r_cmd.slot    <= i_slot;
            r_cmd.len     <= w_len;
            r_cmd.payload <= i_payload;
        end
        if (w_ctl.commit_en) begin
            r_status      <= n_status;
            r_slot_out    <= n_slot_out;
            r_hit         <= n_hit;
            r_ident_out   <= n_ident_out;
            r_dlc_out     <= n_dlc_out;
            r_payload_out <= n_payload_out;
        end
    end

    assign o_status      = r_status;
    assign o_slot_out    = r_slot_out;
    assign o_hit         = r_hit;
    assign o_ident_out   = r_ident_out;
    assign o_dlc_out     = r_dlc_out;
    assign o_payload_out = r_payload_out;

endmodule
